FILE: rtl/mtep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_pkg: shared types for the MIDI track event parser
// Item and result records, event kind codes and decode constants.
// ----------------------------------------------------------------------------
package mtep_pkg;

    typedef enum logic [2:0] {
        KIND_RELEASE = 3'd0,
        KIND_PRESS   = 3'd1,
        KIND_AFTER   = 3'd2,
        KIND_TEMPO   = 3'd3,
        KIND_END     = 3'd4,
        KIND_UNKNOWN = 3'd5,
        KIND_ERROR   = 3'd6
    } kind_t;

    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_AFTER     = 4'hA;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_PRESSURE  = 4'hD;
    localparam logic [3:0] HI_META      = 4'hF;
    localparam logic [7:0] META_END     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        track_start;
        logic [15:0] track_number;
    } mtep_item_t;

    typedef struct packed {
        logic [31:0] abs_tick;
        kind_t       event_kind;
        logic [3:0]  channel;
        logic [7:0]  note;
        logic [7:0]  velocity;
        logic [31:0] tempo;
        logic [15:0] track_tag;
        logic [31:0] kept_count;
    } mtep_result_t;

endpackage
`default_nettype wire

FILE: rtl/mtep_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_in_reg: input register
// Capture one track byte per transfer and hold it until the parser takes it.
// ----------------------------------------------------------------------------
module mtep_in_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire mtep_pkg::mtep_item_t in_item,
    input  wire logic               consume,
    output logic                    item_valid,
    output mtep_pkg::mtep_item_t    item
);
    import mtep_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    mtep_item_t item_reg;

    // stall only while a held byte is not taken this cycle
    assign in_stall   = valid_reg && !consume;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

FILE: rtl/mtep_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_parser: track event decoder
// Parser state and the per-byte decode of delta times, channel and meta events.
// ----------------------------------------------------------------------------
module mtep_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire mtep_pkg::mtep_item_t item,
    output logic                      res_valid,
    output mtep_pkg::mtep_result_t    res
);
    import mtep_pkg::*;

    typedef enum logic [3:0] {
        PH_DELTA  = 4'd0,
        PH_STATUS = 4'd1,
        PH_DATA1  = 4'd2,
        PH_DATA2  = 4'd3,
        PH_MTYPE  = 4'd4,
        PH_TLEN   = 4'd5,
        PH_TBYTES = 4'd6,
        PH_MLEN   = 4'd7,
        PH_MSKIP  = 4'd8,
        PH_ENDED  = 4'd9
    } phase_t;

    phase_t      phase_reg,  phase_next,  phase_cur;
    logic [31:0] delta_reg,  delta_next,  delta_cur;
    logic [31:0] tick_reg,   tick_next,   tick_cur;
    logic [7:0]  status_reg, status_next, status_cur;
    logic [7:0]  first_reg,  first_next,  first_cur;
    logic [31:0] skip_reg,   skip_next,   skip_cur;
    logic [31:0] tempo_reg,  tempo_next,  tempo_cur;
    logic [7:0]  count_reg,  count_next,  count_cur;
    logic [31:0] total_reg,  total_next;

    logic        emit;
    kind_t       kind;
    logic [3:0]  chan;
    logic [7:0]  note_val;
    logic [7:0]  vel_val;
    logic [31:0] tempo_out;
    logic [31:0] delta_acc;
    logic [31:0] skip_acc;
    logic [31:0] tempo_acc;
    logic [7:0]  b;
    logic [3:0]  hi;

    assign b  = item.data_byte;
    assign hi = status_cur[7:4];

    // track start clears the parser and the tick before the byte is decoded
    always_comb
    begin
        if (item.track_start)
        begin
            phase_cur  = PH_DELTA;
            delta_cur  = '0;
            tick_cur   = '0;
            status_cur = '0;
            first_cur  = '0;
            skip_cur   = '0;
            tempo_cur  = '0;
            count_cur  = '0;
        end
        else
        begin
            phase_cur  = phase_reg;
            delta_cur  = delta_reg;
            tick_cur   = tick_reg;
            status_cur = status_reg;
            first_cur  = first_reg;
            skip_cur   = skip_reg;
            tempo_cur  = tempo_reg;
            count_cur  = count_reg;
        end
    end

    assign delta_acc = {delta_cur[24:0], b[6:0]};
    assign skip_acc  = {skip_cur[24:0], b[6:0]};
    assign tempo_acc = {tempo_cur[23:0], b};

    always_comb
    begin
        phase_next  = phase_cur;
        delta_next  = delta_cur;
        tick_next   = tick_cur;
        status_next = status_cur;
        first_next  = first_cur;
        skip_next   = skip_cur;
        tempo_next  = tempo_cur;
        count_next  = count_cur;
        emit        = 1'b0;
        kind        = KIND_UNKNOWN;
        chan        = '0;
        note_val    = '0;
        vel_val     = '0;
        tempo_out   = '0;

        unique case (phase_cur)
            PH_DELTA:
            begin
                if (!b[7])
                begin
                    tick_next  = tick_cur + delta_acc;
                    delta_next = '0;
                    phase_next = PH_STATUS;
                end
                else
                begin
                    delta_next = delta_acc;
                end
            end
            PH_STATUS:
            begin
                if (!b[7])
                begin
                    // data byte where a status belongs: drop the event
                    phase_next  = PH_DELTA;
                    delta_next  = '0;
                    status_next = '0;
                    first_next  = '0;
                    skip_next   = '0;
                    tempo_next  = '0;
                    count_next  = '0;
                    emit        = 1'b1;
                    kind        = KIND_ERROR;
                end
                else
                begin
                    status_next = b;
                    phase_next  = (b[7:4] == HI_META) ? PH_MTYPE : PH_DATA1;
                end
            end
            PH_DATA1:
            begin
                first_next = b;
                if (hi == HI_PROGRAM || hi == HI_PRESSURE)
                begin
                    emit       = 1'b1;
                    kind       = KIND_UNKNOWN;
                    chan       = status_cur[3:0];
                    phase_next = PH_DELTA;
                end
                else
                begin
                    phase_next = PH_DATA2;
                end
            end
            PH_DATA2:
            begin
                emit       = 1'b1;
                chan       = status_cur[3:0];
                phase_next = PH_DELTA;
                case (hi)
                    HI_NOTE_OFF, HI_NOTE_ON, HI_AFTER:
                    begin
                        note_val = first_cur;
                        vel_val  = b;
                        if (hi == HI_AFTER)
                        begin
                            kind = KIND_AFTER;
                        end
                        else if (hi == HI_NOTE_ON && b != 8'd0)
                        begin
                            kind = KIND_PRESS;
                        end
                        else
                        begin
                            kind = KIND_RELEASE;
                        end
                    end
                    default:
                    begin
                        kind = KIND_UNKNOWN;
                    end
                endcase
            end
            PH_MTYPE:
            begin
                if (b == META_END)
                begin
                    emit       = 1'b1;
                    kind       = KIND_END;
                    phase_next = PH_ENDED;
                end
                else if (b == META_TEMPO)
                begin
                    phase_next = PH_TLEN;
                end
                else
                begin
                    skip_next  = '0;
                    phase_next = PH_MLEN;
                end
            end
            PH_TLEN:
            begin
                count_next = b;
                tempo_next = '0;
                if (b == 8'd0)
                begin
                    emit       = 1'b1;
                    kind       = KIND_TEMPO;
                    phase_next = PH_DELTA;
                end
                else
                begin
                    phase_next = PH_TBYTES;
                end
            end
            PH_TBYTES:
            begin
                tempo_next = tempo_acc;
                count_next = count_cur - 8'd1;
                if (count_next == 8'd0)
                begin
                    emit       = 1'b1;
                    kind       = KIND_TEMPO;
                    tempo_out  = tempo_acc;
                    phase_next = PH_DELTA;
                end
            end
            PH_MLEN:
            begin
                skip_next = skip_acc;
                if (!b[7])
                begin
                    if (skip_acc == 32'd0)
                    begin
                        emit       = 1'b1;
                        kind       = KIND_UNKNOWN;
                        phase_next = PH_DELTA;
                    end
                    else
                    begin
                        phase_next = PH_MSKIP;
                    end
                end
            end
            PH_MSKIP:
            begin
                skip_next = skip_cur - 32'd1;
                if (skip_next == 32'd0)
                begin
                    emit       = 1'b1;
                    kind       = KIND_UNKNOWN;
                    phase_next = PH_DELTA;
                end
            end
            default:
            begin
                // after end of track: ignore everything until a track start
                phase_next = PH_ENDED;
            end
        endcase

        total_next = total_reg;
        if (emit && (kind == KIND_RELEASE || kind == KIND_PRESS ||
                     kind == KIND_AFTER || kind == KIND_TEMPO))
        begin
            total_next = total_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DELTA;
            delta_reg  <= '0;
            tick_reg   <= '0;
            status_reg <= '0;
            first_reg  <= '0;
            skip_reg   <= '0;
            tempo_reg  <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            delta_reg  <= delta_next;
            tick_reg   <= tick_next;
            status_reg <= status_next;
            first_reg  <= first_next;
            skip_reg   <= skip_next;
            tempo_reg  <= tempo_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
        end
    end

    assign res_valid      = emit;
    assign res.abs_tick   = tick_next;
    assign res.event_kind = kind;
    assign res.channel    = chan;
    assign res.note       = note_val;
    assign res.velocity   = vel_val;
    assign res.tempo      = tempo_out;
    assign res.track_tag  = item.track_number;
    assign res.kept_count = total_next;

endmodule
`default_nettype wire

FILE: rtl/mtep_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_out_reg: result register
// Hold one decoded event until the downstream side takes it.
// ----------------------------------------------------------------------------
module mtep_out_reg (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire mtep_pkg::mtep_result_t res,
    output logic                        out_free,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output mtep_pkg::mtep_result_t      out_res
);
    import mtep_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    mtep_result_t res_reg;

    // free when empty or when the held result leaves this cycle
    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && out_free)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
`default_nettype wire

FILE: rtl/midi_track_event_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_parser_top: Standard MIDI File track event parser
// Decodes track body bytes into timed note, tempo and end-of-track events.
// ----------------------------------------------------------------------------
// Feed the body of one track, one byte per transfer, with track_start set on
// its first byte. The block takes one byte every cycle while not stalled: a
// byte waits in the input register, is decoded in one pass against the parser
// state, and any event it completes is registered in the result register,
// from which it leaves when the sink does not stall. The only thing that slows
// intake is the result register: while it holds an event that the sink
// stalls, the byte in the input register waits and in_stall rises. Delta
// times accumulate into abs_tick (wrapping at 2^32, cleared by track_start).
// Note on with velocity zero reports as a release; control, program,
// pressure, bend and unknown meta events report as unknown. A data byte
// where a status byte is expected reports an error and restarts parsing at a
// delta time; running status is not supported. After end of track, bytes are
// dropped silently until the next track_start. kept_count counts release,
// press, aftertouch and tempo events since reset.
// ----------------------------------------------------------------------------
module midi_track_event_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        track_start,
    input  wire logic [15:0] track_number,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      abs_tick,
    output logic [2:0]       event_kind,
    output logic [3:0]       channel,
    output logic [7:0]       note,
    output logic [7:0]       velocity,
    output logic [31:0]      tempo,
    output logic [15:0]      track_tag,
    output logic [31:0]      kept_count
);
    import mtep_pkg::*;

    mtep_item_t   in_item;
    mtep_item_t   item;
    logic         item_valid;
    logic         fire;
    logic         out_free;
    logic         res_valid;
    mtep_result_t res;
    mtep_result_t out_res;

    assign in_item.data_byte    = data_byte;
    assign in_item.track_start  = track_start;
    assign in_item.track_number = track_number;

    // decode the held byte whenever the result register can take its outcome
    assign fire = item_valid && out_free;

    mtep_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .consume    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    mtep_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    mtep_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign abs_tick   = out_res.abs_tick;
    assign event_kind = out_res.event_kind;
    assign channel    = out_res.channel;
    assign note       = out_res.note;
    assign velocity   = out_res.velocity;
    assign tempo      = out_res.tempo;
    assign track_tag  = out_res.track_tag;
    assign kept_count = out_res.kept_count;

`ifndef NO_ASSERTIONS
    // an empty input register never holds off the source
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> !in_stall)
        else $error("input stalled with an empty input register");

    // a free result register means the held byte is decoded this cycle
    a_free_fires: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && out_free |-> !in_stall)
        else $error("byte held although the result register was free");

    // only note and aftertouch events carry note and velocity fields
    a_note_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == KIND_TEMPO || event_kind == KIND_END ||
                      event_kind == KIND_UNKNOWN || event_kind == KIND_ERROR)
        |-> note == 8'd0 && velocity == 8'd0)
        else $error("non-note event with note fields set");

    // only tempo events carry a tempo value
    a_tempo_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_TEMPO |-> tempo == 32'd0)
        else $error("non-tempo event with a tempo value");

    // a decoded event reaches the result register in the next cycle
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid |=> out_valid)
        else $error("decoded event lost before the result register");
`endif

endmodule
`default_nettype wire
